@@ rtl/core/qrs_pkg.sv @@
`default_nettype none

package qrs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // root_kind codes
    localparam logic [1:0] KIND_TWO_REAL = 2'd0;
    localparam logic [1:0] KIND_DOUBLE   = 2'd1;
    localparam logic [1:0] KIND_COMPLEX  = 2'd2;

endpackage

`default_nettype wire

@@ rtl/core/qrs_div_pipe.sv @@
`default_nettype none

module qrs_div_pipe #(
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [WORD_BITS+FRAC_BITS+1:0] i_num,
    input  wire logic [WORD_BITS:0]             i_den,
    input  wire logic                           i_neg,
    output logic      [WORD_BITS-1:0]           o_quot,
    output logic                                o_ovf,
    output logic                                o_neg
);
    localparam int W  = WORD_BITS;
    localparam int NB = WORD_BITS + FRAC_BITS + 2;

    // one quotient bit per stage, restoring
    logic [NB-1:0] r_num  [1:NB-1];
    logic [W:0]    r_rem  [1:NB-1];
    logic [W-1:0]  r_q    [1:NB];
    logic          r_ovf  [1:NB];
    logic          r_neg  [1:NB];
    logic [W:0]    r_den  [1:NB-1];

    genvar k;
    generate
        for (k = 0; k < NB; k++) begin : g_stg
            logic [NB-1:0] c_num;
            logic [W:0]    c_rem;
            logic [W-1:0]  c_q;
            logic          c_ovf;
            logic          c_neg;
            logic [W:0]    c_den;
            logic [W+1:0]  rem_sh;
            logic          take;
            logic [W+1:0]  rem_sub;

            if (k == 0) begin : g_in
                assign c_num = i_num;
                assign c_rem = '0;
                assign c_q   = '0;
                assign c_ovf = 1'b0;
                assign c_neg = i_neg;
                assign c_den = i_den;
            end else begin : g_mid
                assign c_num = r_num[k];
                assign c_rem = r_rem[k];
                assign c_q   = r_q[k];
                assign c_ovf = r_ovf[k];
                assign c_neg = r_neg[k];
                assign c_den = r_den[k];
            end

            assign rem_sh  = {c_rem, c_num[NB-1]};
            assign take    = rem_sh >= {1'b0, c_den};
            assign rem_sub = rem_sh - {1'b0, c_den};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[k+1]   <= {c_q[W-2:0], take};
                    r_ovf[k+1] <= c_ovf | c_q[W-1];
                    r_neg[k+1] <= c_neg;
                end
            end

            if (k < NB - 1) begin : g_num
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_num[k+1] <= c_num << 1;
                        r_rem[k+1] <= take ? rem_sub[W:0] : rem_sh[W:0];
                        r_den[k+1] <= c_den;
                    end
                end
            end
        end
    endgenerate

    assign o_quot = r_q[NB];
    assign o_ovf  = r_ovf[NB];
    assign o_neg  = r_neg[NB];

endmodule

`default_nettype wire

@@ rtl/core/quadratic_root_solver.sv @@
// Quadratic root solver: roots of a*x^2 + b*x + c, signed fixed point.
// Input channel: i_valid / o_stall carry one coefficient word (a, b, c).
// Output channel: o_valid / i_stall carry one result word per input word:
// root kind, two values, degenerate and saturated flags.
// A word is taken at each edge with valid high and stall low.
// Throughput: one word per cycle while the receiver does not stall, fully pipelined.
// Pipeline: stages for magnitudes, products and discriminant, WORD_BITS+1
// square-root stages, one numerator stage, WORD_BITS+FRAC_BITS+2 divider
// stages (two dividers in parallel, one quotient bit per stage) and the
// output register.
// A zero leading coefficient gives degenerate = 1 with zero values.
// Reset (synchronous, active low) drops all words in flight; o_valid falls.
// While the receiver stalls a valid result, the whole pipeline holds and
// o_stall is raised; nothing is lost or repeated.
`default_nettype none

module quadratic_root_solver #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic signed [WORD_BITS-1:0] i_coef_a,
    input  wire logic signed [WORD_BITS-1:0] i_coef_b,
    input  wire logic signed [WORD_BITS-1:0] i_coef_c,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic             [1:0]           o_root_kind,
    output logic signed      [WORD_BITS-1:0] o_first_value,
    output logic signed      [WORD_BITS-1:0] o_second_value,
    output logic                             o_degenerate,
    output logic                             o_saturated
);
    import qrs_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int DW = 2 * WORD_BITS + 2;
    localparam int NS = WORD_BITS + 1;
    localparam int NB = WORD_BITS + FRAC_BITS + 2;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage 1: magnitudes
    logic            r_s1_vld;
    logic [W-1:0]    r_s1_amag, r_s1_bmag, r_s1_cmag;
    logic            r_s1_aneg, r_s1_cneg, r_s1_czero, r_s1_degen;
    logic signed [W-1:0] r_s1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_amag  <= i_coef_a[W-1] ? W'(-i_coef_a) : W'(i_coef_a);
            r_s1_bmag  <= i_coef_b[W-1] ? W'(-i_coef_b) : W'(i_coef_b);
            r_s1_cmag  <= i_coef_c[W-1] ? W'(-i_coef_c) : W'(i_coef_c);
            r_s1_aneg  <= i_coef_a[W-1];
            r_s1_cneg  <= i_coef_c[W-1];
            r_s1_czero <= i_coef_c == '0;
            r_s1_degen <= i_coef_a == '0;
            r_s1_b     <= i_coef_b;
        end
    end

    // stage 2: b*b and a*c
    logic            r_s2_vld;
    logic [2*W-1:0]  r_s2_bb, r_s2_ac;
    logic [W-1:0]    r_s2_amag;
    logic            r_s2_aneg, r_s2_cneg, r_s2_czero, r_s2_degen;
    logic signed [W-1:0] r_s2_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_bb    <= r_s1_bmag * r_s1_bmag;
            r_s2_ac    <= r_s1_amag * r_s1_cmag;
            r_s2_amag  <= r_s1_amag;
            r_s2_aneg  <= r_s1_aneg;
            r_s2_cneg  <= r_s1_cneg;
            r_s2_czero <= r_s1_czero;
            r_s2_degen <= r_s1_degen;
            r_s2_b     <= r_s1_b;
        end
    end

    // stage 3: |d| and its sign
    logic [DW-1:0] bb_x, fac;
    logic          opposite, bb_ge;
    logic [DW-1:0] n_s3_d;
    logic          n_s3_dneg;

    assign bb_x     = DW'(r_s2_bb);
    assign fac      = {r_s2_ac, 2'b00};
    assign opposite = (r_s2_aneg != r_s2_cneg) && !r_s2_czero;
    assign bb_ge    = bb_x >= fac;

    always_comb begin
        n_s3_dneg = 1'b0;
        priority if (opposite) begin
            n_s3_d = bb_x + fac;
        end else if (bb_ge) begin
            n_s3_d = bb_x - fac;
        end else begin
            n_s3_d    = fac - bb_x;
            n_s3_dneg = 1'b1;
        end
    end

    logic            r_s3_vld;
    logic [DW-1:0]   r_s3_d;
    logic            r_s3_dneg, r_s3_dzero, r_s3_aneg, r_s3_degen;
    logic [W-1:0]    r_s3_amag;
    logic signed [W-1:0] r_s3_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_d     <= n_s3_d;
            r_s3_dneg  <= n_s3_dneg;
            r_s3_dzero <= n_s3_d == '0;
            r_s3_aneg  <= r_s2_aneg;
            r_s3_degen <= r_s2_degen;
            r_s3_amag  <= r_s2_amag;
            r_s3_b     <= r_s2_b;
        end
    end

    // square root, two radicand bits per stage
    logic [DW-1:0]   r_sq_d     [1:NS-1];
    logic [W+2:0]    r_sq_rem   [1:NS-1];
    logic [W:0]      r_sq_root  [1:NS];
    logic            r_sq_vld   [1:NS];
    logic            r_sq_dneg  [1:NS];
    logic            r_sq_dzero [1:NS];
    logic            r_sq_aneg  [1:NS];
    logic            r_sq_degen [1:NS];
    logic [W-1:0]    r_sq_amag  [1:NS];
    logic [W-1:0]    r_sq_b     [1:NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_sq
            logic [DW-1:0] c_d;
            logic [W+2:0]  c_rem;
            logic [W:0]    c_root;
            logic          c_vld, c_dneg, c_dzero, c_aneg, c_degen;
            logic [W-1:0]  c_amag, c_b;
            logic [W+2:0]  rem_sh, trial;
            logic          take;

            if (k == 0) begin : g_in
                assign c_d     = r_s3_d;
                assign c_rem   = '0;
                assign c_root  = '0;
                assign c_vld   = r_s3_vld;
                assign c_dneg  = r_s3_dneg;
                assign c_dzero = r_s3_dzero;
                assign c_aneg  = r_s3_aneg;
                assign c_degen = r_s3_degen;
                assign c_amag  = r_s3_amag;
                assign c_b     = r_s3_b;
            end else begin : g_mid
                assign c_d     = r_sq_d[k];
                assign c_rem   = r_sq_rem[k];
                assign c_root  = r_sq_root[k];
                assign c_vld   = r_sq_vld[k];
                assign c_dneg  = r_sq_dneg[k];
                assign c_dzero = r_sq_dzero[k];
                assign c_aneg  = r_sq_aneg[k];
                assign c_degen = r_sq_degen[k];
                assign c_amag  = r_sq_amag[k];
                assign c_b     = r_sq_b[k];
            end

            assign rem_sh = {c_rem[W:0], c_d[DW-1 -: 2]};
            assign trial  = {c_root, 2'b01};
            assign take   = rem_sh >= trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[k+1] <= 1'b0;
                end else if (en) begin
                    r_sq_vld[k+1] <= c_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq_root[k+1]  <= {c_root[W-1:0], take};
                    r_sq_dneg[k+1]  <= c_dneg;
                    r_sq_dzero[k+1] <= c_dzero;
                    r_sq_aneg[k+1]  <= c_aneg;
                    r_sq_degen[k+1] <= c_degen;
                    r_sq_amag[k+1]  <= c_amag;
                    r_sq_b[k+1]     <= c_b;
                end
            end

            if (k < NS - 1) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_sq_d[k+1]   <= c_d << 2;
                        r_sq_rem[k+1] <= take ? rem_sh - trial : rem_sh;
                    end
                end
            end
        end
    endgenerate

    // numerator stage
    logic [1:0]          nm_kind;
    logic signed [W+1:0] nm_nb, nm_s, nm_n1, nm_n2;
    logic [W+1:0]        nm_abs1, nm_abs2;
    logic                nm_neg1, nm_neg2, nm_dsg2;

    always_comb begin
        nm_nb = -{{2{r_sq_b[NS][W-1]}}, r_sq_b[NS]};
        nm_s  = {1'b0, r_sq_root[NS]};
        priority if (r_sq_dneg[NS]) begin
            nm_kind = KIND_COMPLEX;
        end else if (r_sq_dzero[NS]) begin
            nm_kind = KIND_DOUBLE;
        end else begin
            nm_kind = KIND_TWO_REAL;
        end
        unique case (nm_kind)
            KIND_COMPLEX: begin
                nm_n1   = nm_nb;
                nm_n2   = nm_s;
                nm_dsg2 = 1'b0;
            end
            KIND_DOUBLE: begin
                nm_n1   = nm_nb;
                nm_n2   = nm_nb;
                nm_dsg2 = r_sq_aneg[NS];
            end
            default: begin
                nm_n1   = nm_nb + nm_s;
                nm_n2   = nm_nb - nm_s;
                nm_dsg2 = r_sq_aneg[NS];
            end
        endcase
        nm_abs1 = nm_n1[W+1] ? -nm_n1 : nm_n1;
        nm_abs2 = nm_n2[W+1] ? -nm_n2 : nm_n2;
        nm_neg1 = (nm_n1[W+1] ^ r_sq_aneg[NS]) && (nm_n1 != '0);
        nm_neg2 = (nm_n2[W+1] ^ nm_dsg2) && (nm_n2 != '0);
    end

    logic            r_nm_vld;
    logic [NB-1:0]   r_nm_num1, r_nm_num2;
    logic [W:0]      r_nm_den;
    logic            r_nm_neg1, r_nm_neg2, r_nm_degen;
    logic [1:0]      r_nm_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_vld <= 1'b0;
        end else if (en) begin
            r_nm_vld <= r_sq_vld[NS];
        end
    end

    // |n| scaled by 2^FRAC_BITS plus half the divisor, for round half up
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nm_num1  <= {1'b0, nm_abs1[W:0], {FRAC_BITS{1'b0}}} + NB'(r_sq_amag[NS]);
            r_nm_num2  <= {1'b0, nm_abs2[W:0], {FRAC_BITS{1'b0}}} + NB'(r_sq_amag[NS]);
            r_nm_den   <= {r_sq_amag[NS], 1'b0};
            r_nm_neg1  <= nm_neg1;
            r_nm_neg2  <= nm_neg2;
            r_nm_degen <= r_sq_degen[NS];
            r_nm_kind  <= nm_kind;
        end
    end

    // dividers
    logic [W-1:0] dv_q1, dv_q2;
    logic         dv_ovf1, dv_ovf2, dv_neg1, dv_neg2;

    qrs_div_pipe #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_div_first (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_nm_num1),
        .i_den (r_nm_den),
        .i_neg (r_nm_neg1),
        .o_quot(dv_q1),
        .o_ovf (dv_ovf1),
        .o_neg (dv_neg1)
    );

    qrs_div_pipe #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_div_second (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_nm_num2),
        .i_den (r_nm_den),
        .i_neg (r_nm_neg2),
        .o_quot(dv_q2),
        .o_ovf (dv_ovf2),
        .o_neg (dv_neg2)
    );

    logic       r_dl_vld   [1:NB];
    logic       r_dl_degen [1:NB];
    logic [1:0] r_dl_kind  [1:NB];

    generate
        for (k = 0; k < NB; k++) begin : g_dl
            logic       c_vld, c_degen;
            logic [1:0] c_kind;

            if (k == 0) begin : g_in
                assign c_vld   = r_nm_vld;
                assign c_degen = r_nm_degen;
                assign c_kind  = r_nm_kind;
            end else begin : g_mid
                assign c_vld   = r_dl_vld[k];
                assign c_degen = r_dl_degen[k];
                assign c_kind  = r_dl_kind[k];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dl_vld[k+1] <= 1'b0;
                end else if (en) begin
                    r_dl_vld[k+1] <= c_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dl_degen[k+1] <= c_degen;
                    r_dl_kind[k+1]  <= c_kind;
                end
            end
        end
    endgenerate

    // clamp and sign
    logic [W-1:0] lim1, lim2, m1, m2;
    logic         sat1, sat2;

    always_comb begin
        lim1 = dv_neg1 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        lim2 = dv_neg2 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        sat1 = dv_ovf1 || (dv_q1 > lim1);
        sat2 = dv_ovf2 || (dv_q2 > lim2);
        m1   = sat1 ? lim1 : dv_q1;
        m2   = sat2 ? lim2 : dv_q2;
    end

    logic               r_out_vld;
    logic [1:0]         r_out_kind;
    logic signed [W-1:0] r_out_v1, r_out_v2;
    logic               r_out_degen, r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dl_vld[NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_dl_degen[NB]) begin
                r_out_kind <= KIND_TWO_REAL;
                r_out_v1   <= '0;
                r_out_v2   <= '0;
                r_out_sat  <= 1'b0;
            end else begin
                r_out_kind <= r_dl_kind[NB];
                r_out_v1   <= dv_neg1 ? -m1 : m1;
                r_out_v2   <= dv_neg2 ? -m2 : m2;
                r_out_sat  <= sat1 | sat2;
            end
            r_out_degen <= r_dl_degen[NB];
        end
    end

    assign o_valid        = r_out_vld;
    assign o_root_kind    = r_out_kind;
    assign o_first_value  = r_out_v1;
    assign o_second_value = r_out_v2;
    assign o_degenerate   = r_out_degen;
    assign o_saturated    = r_out_sat;

endmodule

`default_nettype wire

@@ rtl/core/qrs_checker.sv @@
`default_nettype none

module qrs_checker #(
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_stall,
    input wire logic                 o_valid,
    input wire logic [1:0]           o_root_kind,
    input wire logic [WORD_BITS-1:0] o_first_value,
    input wire logic [WORD_BITS-1:0] o_second_value,
    input wire logic                 o_degenerate,
    input wire logic                 o_saturated
);
    import qrs_pkg::*;

    // a zero leading coefficient yields zero values, kind two-real and no saturation
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_first_value == '0 && o_second_value == '0
            && !o_saturated && o_root_kind == KIND_TWO_REAL)
        else $error("degenerate word carries nonzero fields");

    a_double_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == KIND_DOUBLE |-> o_first_value == o_second_value)
        else $error("double root values differ");

    a_imag_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == KIND_COMPLEX |-> !o_second_value[WORD_BITS-1])
        else $error("imaginary magnitude negative");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_first_value)
            && $stable(o_second_value) && $stable(o_root_kind))
        else $error("stalled word changed");

endmodule

bind quadratic_root_solver qrs_checker #(
    .WORD_BITS(WORD_BITS)
) u_qrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_stall       (i_stall),
    .o_valid       (o_valid),
    .o_root_kind   (o_root_kind),
    .o_first_value (o_first_value),
    .o_second_value(o_second_value),
    .o_degenerate  (o_degenerate),
    .o_saturated   (o_saturated)
);

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
    import qrs_pkg::*;

    localparam int FB = 16;
    localparam int WB = 32;
    localparam int LAT = 2 * WB + FB + 8;

    typedef struct packed {
        logic signed [WB-1:0] a;
        logic signed [WB-1:0] b;
        logic signed [WB-1:0] c;
    } t_coef;

    typedef struct packed {
        logic [1:0]           kind;
        logic signed [WB-1:0] v1;
        logic signed [WB-1:0] v2;
        logic                 degen;
        logic                 sat;
    } t_roots;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_valid = 0;
    logic                 o_stall;
    logic signed [WB-1:0] i_coef_a = '0, i_coef_b = '0, i_coef_c = '0;
    logic                 o_valid;
    logic                 i_stall = 0;
    logic [1:0]           o_root_kind;
    logic signed [WB-1:0] o_first_value, o_second_value;
    logic                 o_degenerate, o_saturated;

    quadratic_root_solver u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_coef_a(i_coef_a), .i_coef_b(i_coef_b), .i_coef_c(i_coef_c),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_root_kind(o_root_kind), .o_first_value(o_first_value),
        .o_second_value(o_second_value), .o_degenerate(o_degenerate),
        .o_saturated(o_saturated)
    );

    t_coef  coef_q[$];
    t_roots roots_q[$];
    int     errors = 0;
    int     n_sent = 0, n_got = 0, n_sat = 0, n_cplx = 0, n_dbl = 0;
    bit     quiet_tx = 0, quiet_rx = 0;
    bit     hold_rx = 0;
    int     hold_cnt = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // rounded quotient |n|*2^FB/|den|, signed and clamped
    function automatic logic [WB-1:0] div_round(input logic signed [127:0] n,
                                               input logic signed [127:0] den,
                                               inout bit sat);
        logic [127:0] mn, md, q, lim;
        bit neg;
        mn = n < 0 ? -n : n;
        md = den < 0 ? -den : den;
        neg = (n < 0) != (den < 0);
        if (n == 0) neg = 0;
        q = ((mn << FB) + (md >> 1)) / md;
        lim = (128'd1 << (WB - 1)) - (neg ? 0 : 1);
        if (q > lim) begin
            q = lim;
            sat = 1;
        end
        return neg ? -q[WB-1:0] : q[WB-1:0];
    endfunction

    function automatic logic [127:0] isqrt(input logic [127:0] x);
        logic [127:0] r;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            if ((r | (128'd1 << i)) * (r | (128'd1 << i)) <= x) r |= 128'd1 << i;
        end
        return r;
    endfunction

    function automatic t_roots solve_roots(input t_coef w);
        t_roots r;
        logic signed [127:0] a, b, c, d, s;
        bit sat;
        r = '0;
        sat = 0;
        a = w.a; b = w.b; c = w.c;
        if (a == 0) begin
            r.degen = 1;
            return r;
        end
        d = b * b - 4 * a * c;
        s = isqrt(d < 0 ? -d : d);
        if (d < 0) begin
            r.kind = KIND_COMPLEX;
            r.v1 = div_round(-b, 2 * a, sat);
            r.v2 = div_round(s, a < 0 ? -2 * a : 2 * a, sat);
        end else if (d == 0) begin
            r.kind = KIND_DOUBLE;
            r.v1 = div_round(-b, 2 * a, sat);
            r.v2 = r.v1;
        end else begin
            r.kind = KIND_TWO_REAL;
            r.v1 = div_round(-b + s, 2 * a, sat);
            r.v2 = div_round(-b - s, 2 * a, sat);
        end
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [WB-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            3: return $signed($urandom_range(0, 600)) - 300;
            4: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
            default: return $signed(32'($urandom_range(0, 40)) - 20) <<< FB;
        endcase
    endfunction

    task automatic push_coef(input logic [WB-1:0] a, b, c);
        t_coef w;
        w.a = a; w.b = b; w.c = c;
        coef_q.push_back(w);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_valid && o_stall)) begin
                if (coef_q.size() > 0 && (quiet_tx || $urandom_range(0, 99) >= 17)) begin
                    t_coef w;
                    w = coef_q.pop_front();
                    i_coef_a <= w.a; i_coef_b <= w.b; i_coef_c <= w.c;
                    i_valid <= 1;
                    roots_q.push_back(solve_roots(w));
                    n_sent++;
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_rx && hold_cnt < 300) begin
            i_stall <= 1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_stall <= !quiet_rx && $urandom_range(0, 99) < 17;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_roots e;
            if (roots_q.size() == 0) begin
                $error("unexpected result word");
                errors++;
            end else begin
                e = roots_q.pop_front();
                n_got++;
                if (e.sat) n_sat++;
                if (e.kind == KIND_COMPLEX) n_cplx++;
                if (e.kind == KIND_DOUBLE) n_dbl++;
                if (o_root_kind !== e.kind) begin
                    $error("root_kind exp %0d got %0d", e.kind, o_root_kind); errors++;
                end
                if (o_first_value !== e.v1) begin
                    $error("first_value exp %h got %h", e.v1, o_first_value); errors++;
                end
                if (o_second_value !== e.v2) begin
                    $error("second_value exp %h got %h", e.v2, o_second_value); errors++;
                end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate exp %b got %b", e.degen, o_degenerate); errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, o_saturated); errors++;
                end
            end
        end
    end

    initial begin
        // directed
        push_coef(0, 32'sh10000, 5);
        push_coef(0, 0, 0);
        push_coef(32'sh10000, 32'shfffd0000, 32'sh20000);  // two real
        push_coef(32'sh10000, 32'shfffe0000, 32'sh10000);  // double
        push_coef(32'sh10000, 0, 32'sh10000);              // complex
        push_coef(32'shffff0000, 32'sh20000, 32'sh30000);  // negative a
        push_coef(1, 32'sh7fffffff, 0);                    // saturates
        push_coef(1, 0, 32'sh7fffffff);                    // complex, saturates
        push_coef(32'sh80000000, 32'sh80000000, 32'sh80000000);
        push_coef(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        push_coef(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        push_coef(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        push_coef(32'shffffffff, 32'shffffffff, 32'shffffffff);
        push_coef(1, 1, 1);
        push_coef(32'sh10000, 32'sh20000, 0);
        push_coef(1, 2, 1);
        push_coef(32'sh80000000, 0, 0);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        for (int i = 0; i < 1700; i++) begin
            logic [WB-1:0] a, b;
            a = rand_coef();
            b = rand_coef();
            if ($urandom_range(0, 9) == 0) push_coef(a, b, 0);
            else if ($urandom_range(0, 19) == 0) push_coef(0, b, rand_coef());
            else if ($urandom_range(0, 9) == 0) begin
                // double root: b = 2k, a = 1, c = k*k (raw ints)
                int k;
                k = $signed(16'($urandom));
                push_coef(1, WB'(2 * k), WB'(k * k));
            end else push_coef(a, b, rand_coef());
        end
        wait (n_sent >= 300);
        hold_rx <= 1;
        wait (n_sent >= 800);
        quiet_tx <= 1; quiet_rx <= 1;
        wait (n_sent >= 1100);
        quiet_tx <= 0; quiet_rx <= 0;
        wait (coef_q.size() == 0 && roots_q.size() == 0);
        repeat (LAT + 20) @(posedge i_clk);
        $display("results %0d of %0d words: %0d complex, %0d double, %0d saturated",
                 n_got, n_sent, n_cplx, n_dbl, n_sat);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire

@@ quadratic_root_solver.f @@
rtl/core/qrs_pkg.sv
rtl/core/qrs_div_pipe.sv
rtl/core/quadratic_root_solver.sv
rtl/core/qrs_checker.sv
tb/tb.sv
